>>> src/aia_pkg.sv
// Shared widths, outcome codes and chain structures for the aging id assigner.
package aia_pkg;

  localparam int KEY_W       = 32;
  localparam int TIME_W      = 32;
  localparam int AGE_W       = 16;
  localparam int SLOT_W      = 5;
  localparam int OUTCOME_W   = 2;

  localparam int SLOTS_DEFAULT = 25;
  localparam int SLOTS_MAX     = 64;
  localparam int IDX_W         = $clog2(SLOTS_MAX);
  localparam int CNT_W         = $clog2(SLOTS_MAX + 1);

  localparam logic [AGE_W-1:0] REUSE_AGE_RESET = AGE_W'(60);

  localparam logic [OUTCOME_W-1:0] OUT_HIT  = 2'd0;
  localparam logic [OUTCOME_W-1:0] OUT_NEW  = 2'd1;
  localparam logic [OUTCOME_W-1:0] OUT_TAKE = 2'd2;
  localparam logic [OUTCOME_W-1:0] OUT_FULL = 2'd3;

  // Request travelling down the cell chain, one cell per cycle.
  typedef struct packed {
    logic              valid;
    logic [KEY_W-1:0]  key;
    logic [TIME_W-1:0] now;
    logic              hit;
    logic              found;
    logic [TIME_W-1:0] old_time;
    logic [IDX_W-1:0]  idx;
  } scan_pkt_t;

  // Write-back broadcast from the controller to all cells.
  typedef struct packed {
    logic              en;
    logic              key_en;
    logic [IDX_W-1:0]  idx;
    logic [KEY_W-1:0]  key;
    logic [TIME_W-1:0] tstamp;
  } wr_cmd_t;

endpackage

>>> src/aia_ifs.sv
// Request and response channel interfaces of the aging id assigner.
interface aia_req_if import aia_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KEY_W-1:0]  key;
  logic [TIME_W-1:0] now;

  modport source (output valid, output key, output now, input ready);
  modport sink   (input valid, input key, input now, output ready);
endinterface

interface aia_rsp_if import aia_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [SLOT_W-1:0]    slot;
  logic [OUTCOME_W-1:0] outcome;

  modport source (output valid, output slot, output outcome, input ready);
  modport sink   (input valid, input slot, input outcome, output ready);
endinterface

>>> src/aia_cell.sv
// One table entry: holds a key and its last-use time and updates the passing scan.
module aia_cell import aia_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [CNT_W-1:0] fill,
  input  scan_pkt_t        pkt_in,
  output scan_pkt_t        pkt_out,
  input  wr_cmd_t          wr
);

  logic [KEY_W-1:0]  key_r;
  logic [TIME_W-1:0] time_r;
  scan_pkt_t         pkt_r;
  scan_pkt_t         pkt_nxt;
  logic              bound;

  assign bound = CNT_W'(IDX) < fill;

  always_comb begin
    pkt_nxt = pkt_in;
    // Once a hit is found, later cells leave the packet alone.
    if (pkt_in.valid && !pkt_in.hit && bound) begin
      if (key_r == pkt_in.key) begin
        pkt_nxt.hit = 1'b1;
        pkt_nxt.idx = IDX_W'(IDX);
      end else if (time_r < pkt_in.old_time) begin
        pkt_nxt.found    = 1'b1;
        pkt_nxt.old_time = time_r;
        pkt_nxt.idx      = IDX_W'(IDX);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pkt_r.valid <= 1'b0;
    end else begin
      pkt_r.valid <= pkt_nxt.valid;
    end
    pkt_r.key      <= pkt_nxt.key;
    pkt_r.now      <= pkt_nxt.now;
    pkt_r.hit      <= pkt_nxt.hit;
    pkt_r.found    <= pkt_nxt.found;
    pkt_r.old_time <= pkt_nxt.old_time;
    pkt_r.idx      <= pkt_nxt.idx;
  end

  always_ff @(posedge clk) begin
    if (wr.en && (wr.idx == IDX_W'(IDX))) begin
      time_r <= wr.tstamp;
      if (wr.key_en) begin
        key_r <= wr.key;
      end
    end
  end

  assign pkt_out = pkt_r;

endmodule

>>> src/aging_id_assigner_unit.sv
// Top level of the aging id assigner: cell chain, commit control and output register.
//
// Each request walks a chain of SLOTS entry cells, one cell per cycle, which
// looks for the key and tracks the oldest bound entry on the way. After the
// last cell the request is captured in the tail register and then committed:
// the hit entry is refreshed, a stale entry is rebound, a new entry is
// appended, or, when the table is full, nothing is written. One request is
// in flight at a time; the next is accepted only after the previous one has
// passed the cell chain and committed. The result sits in an output register,
// so the next request is accepted while a result waits to be taken; a commit
// waits only if the previous result is still held. The reuse age register
// resets to 60 seconds.
module aging_id_assigner_unit import aia_pkg::*; #(
  parameter int SLOTS = SLOTS_DEFAULT
) (
  input  logic             clk,
  input  logic             rst_n,
  aia_req_if.sink          in_chan,
  aia_rsp_if.source        out_chan,
  input  logic             cfg_we,
  input  logic [AGE_W-1:0] cfg_wdata
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_COMMIT = 2'd2;

  logic [1:0]           state_r, state_nxt;
  logic [CNT_W-1:0]     fill_r, fill_nxt;
  logic [AGE_W-1:0]     reuse_age_r;
  scan_pkt_t            tail_r;
  logic                 out_valid_r, out_valid_nxt;
  logic [SLOT_W-1:0]    out_slot_r, out_slot_nxt;
  logic [OUTCOME_W-1:0] out_outcome_r, out_outcome_nxt;

  scan_pkt_t            pkt [SLOTS+1];
  logic [SLOTS-1:0]     stage_valid;
  wr_cmd_t              wr;
  logic                 in_fire;
  logic                 out_free;
  logic                 commit;
  logic [TIME_W-1:0]    age;
  logic                 stale;
  logic [CNT_W+SLOT_W-1:0] slot_wide;

  assign in_chan.ready = (state_r == ST_IDLE);
  assign in_fire       = in_chan.valid && in_chan.ready;
  assign out_free      = !out_valid_r || out_chan.ready;
  assign commit        = (state_r == ST_COMMIT) && out_free;

  assign pkt[0].valid    = in_fire;
  assign pkt[0].key      = in_chan.key;
  assign pkt[0].now      = in_chan.now;
  assign pkt[0].hit      = 1'b0;
  assign pkt[0].found    = 1'b0;
  assign pkt[0].old_time = in_chan.now;
  assign pkt[0].idx      = '0;

  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    aia_cell #(.IDX(g)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .fill    (fill_r),
      .pkt_in  (pkt[g]),
      .pkt_out (pkt[g+1]),
      .wr      (wr)
    );
    assign stage_valid[g] = pkt[g+1].valid;
  end

  // Only entries strictly older than the request reach the tracker, so the
  // age never wraps.
  assign age   = tail_r.now - tail_r.old_time;
  assign stale = tail_r.found && (age > TIME_W'(reuse_age_r));

  always_comb begin
    state_nxt       = state_r;
    fill_nxt        = fill_r;
    out_valid_nxt   = out_valid_r && !out_chan.ready;
    out_slot_nxt    = out_slot_r;
    out_outcome_nxt = out_outcome_r;
    wr              = '0;
    wr.key          = tail_r.key;
    wr.tstamp       = tail_r.now;
    slot_wide       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (pkt[SLOTS].valid) begin
          state_nxt = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (out_free) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          if (tail_r.hit) begin
            wr.en           = 1'b1;
            wr.idx          = tail_r.idx;
            slot_wide       = (CNT_W+SLOT_W)'(tail_r.idx);
            out_outcome_nxt = OUT_HIT;
          end else if (stale) begin
            wr.en           = 1'b1;
            wr.key_en       = 1'b1;
            wr.idx          = tail_r.idx;
            slot_wide       = (CNT_W+SLOT_W)'(tail_r.idx);
            out_outcome_nxt = OUT_TAKE;
          end else if (fill_r >= CNT_W'(SLOTS)) begin
            slot_wide       = (CNT_W+SLOT_W)'(SLOTS);
            out_outcome_nxt = OUT_FULL;
          end else begin
            wr.en           = 1'b1;
            wr.key_en       = 1'b1;
            wr.idx          = fill_r[IDX_W-1:0];
            fill_nxt        = fill_r + CNT_W'(1);
            slot_wide       = (CNT_W+SLOT_W)'(fill_r);
            out_outcome_nxt = OUT_NEW;
          end
          out_slot_nxt = slot_wide[SLOT_W-1:0];
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
      reuse_age_r <= REUSE_AGE_RESET;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        reuse_age_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_slot_r    <= out_slot_nxt;
    out_outcome_r <= out_outcome_nxt;
    if ((state_r == ST_SCAN) && pkt[SLOTS].valid) begin
      tail_r <= pkt[SLOTS];
    end
  end

  assign out_chan.valid   = out_valid_r;
  assign out_chan.slot    = out_slot_r;
  assign out_chan.outcome = out_outcome_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(SLOTS))
    else $error("fill count beyond table size");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(stage_valid))
    else $error("more than one request in the cell chain");

  a_chain_only_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (|stage_valid) |-> (state_r == ST_SCAN))
    else $error("cell chain busy outside scan state");

  a_launch: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> pkt[1].valid)
    else $error("accepted beat did not enter the first cell");

  a_new_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (commit && (out_outcome_nxt == OUT_NEW)) |=> (fill_r == $past(fill_r) + CNT_W'(1)))
    else $error("new slot did not advance the fill count");

endmodule
